FILE: rtl/core/sbi_pkg.sv
`timescale 1ns / 1ps

package sbi_pkg;

    // coordinate width and derived datapath widths
    localparam int W  = 32;
    localparam int MW = W + 1;      // magnitude of a direction or plane offset
    localparam int NW = W + 2;      // signed plane offset before range check
    localparam int PW = 2 * MW;     // product width
    localparam int QW = MW;         // quotient bits, one per divider stage

    localparam int NFACE = 6;
    localparam int NAXIS = 3;

    // input item
    typedef struct packed {
        logic signed [W-1:0] start_x;
        logic signed [W-1:0] start_y;
        logic signed [W-1:0] start_z;
        logic signed [W-1:0] end_x;
        logic signed [W-1:0] end_y;
        logic signed [W-1:0] end_z;
        logic signed [W-1:0] center_x;
        logic signed [W-1:0] center_y;
        logic signed [W-1:0] center_z;
        logic [W-2:0]        half_x;
        logic [W-2:0]        half_y;
        logic [W-2:0]        half_z;
    } t_in;

    // result item
    typedef struct packed {
        logic [1:0]          hit_count;
        logic signed [W-1:0] first_x;
        logic signed [W-1:0] first_y;
        logic signed [W-1:0] first_z;
        logic [2:0]          first_face;
        logic signed [W-1:0] second_x;
        logic signed [W-1:0] second_y;
        logic signed [W-1:0] second_z;
        logic [2:0]          second_face;
    } t_out;

    // per-item data that rides alongside the divider stages
    typedef struct packed {
        logic [NAXIS-1:0][W-1:0]  s;
        logic [NAXIS-1:0][W-1:0]  c;
        logic [NAXIS-1:0][W-2:0]  h;
        logic [NFACE-1:0][W-1:0]  fp;    // face plane coordinate
        logic [NFACE-1:0]         ok;    // segment crosses plane within [0,1]
        logic [NFACE-1:0][MW-1:0] nmag;  // |face - start|
        logic [NAXIS-1:0][MW-1:0] dmag;  // |end - start|
        logic [NFACE-1:0][1:0]    neg;   // sign of offset on each other axis
    } t_cy;

    // one face hit
    typedef struct packed {
        logic [2:0]              face;
        logic [NAXIS-1:0][W-1:0] p;
        logic [MW-1:0]           tn;
        logic [MW-1:0]           td;
    } t_hit;

endpackage

FILE: rtl/core/segment_box_intersection.sv
`timescale 1ns / 1ps

// Segment versus axis-aligned box test, one query per clock.
// Input: raise start with a query on i_item; busy is always low, so every
// cycle with start high is a transfer. The query is a segment (start, end)
// and a box (center, half extents), signed fixed point.
// Output: o_strobe is high for one cycle with the result on o_result: the
// hit count (0..2) and up to two hit points with face codes, nearer first.
// Absent hits read as zero.
// One bit of each hit-point quotient is resolved per stage, so the twelve
// restoring dividers set the pipeline depth. Throughput is one query per
// cycle, sustained.
// Reset clears all stage valid bits; no results appear until new queries
// arrive. The receiver cannot stall; results flow out as they complete.
module segment_box_intersection
    import sbi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    // input register
    logic r_a_vld;
    t_in  r_a_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in <= i_item;
    end

    assign busy = 1'b0;

    // stage B: directions, face planes, plane range check
    logic signed [NW-1:0] b_s [NAXIS];
    logic signed [NW-1:0] b_e [NAXIS];
    logic signed [NW-1:0] b_c [NAXIS];
    logic signed [NW-1:0] b_h [NAXIS];
    t_cy  n_b;
    t_cy  r_b;
    logic r_b_vld;

    assign b_s[0] = NW'(r_a_in.start_x);
    assign b_s[1] = NW'(r_a_in.start_y);
    assign b_s[2] = NW'(r_a_in.start_z);
    assign b_e[0] = NW'(r_a_in.end_x);
    assign b_e[1] = NW'(r_a_in.end_y);
    assign b_e[2] = NW'(r_a_in.end_z);
    assign b_c[0] = NW'(r_a_in.center_x);
    assign b_c[1] = NW'(r_a_in.center_y);
    assign b_c[2] = NW'(r_a_in.center_z);
    assign b_h[0] = $signed(NW'(r_a_in.half_x));
    assign b_h[1] = $signed(NW'(r_a_in.half_y));
    assign b_h[2] = $signed(NW'(r_a_in.half_z));

    always_comb begin
        logic signed [NW-1:0] d [NAXIS];
        logic signed [NW-1:0] fv;
        logic signed [NW-1:0] num;
        logic signed [NW-1:0] am;
        int a;
        int j;
        n_b = '0;
        for (int x = 0; x < NAXIS; x++) begin
            d[x] = b_e[x] - b_s[x];
            am = (d[x] < 0) ? -d[x] : d[x];
            n_b.s[x]    = b_s[x][W-1:0];
            n_b.c[x]    = b_c[x][W-1:0];
            n_b.h[x]    = b_h[x][W-2:0];
            n_b.dmag[x] = am[MW-1:0];
        end
        for (int f = 0; f < NFACE; f++) begin
            a = f / 2;
            fv = (f % 2 == 0) ? b_c[a] + b_h[a] : b_c[a] - b_h[a];
            num = fv - b_s[a];
            am = (num < 0) ? -num : num;
            n_b.fp[f]   = fv[W-1:0];
            n_b.nmag[f] = am[MW-1:0];
            if (d[a] > 0) begin
                n_b.ok[f] = (num >= 0) && (num <= d[a]);
            end else if (d[a] < 0) begin
                n_b.ok[f] = (num <= 0) && (num >= d[a]);
            end else begin
                n_b.ok[f] = 1'b0;
            end
            for (int o = 0; o < 2; o++) begin
                j = (a + 1 + o) % NAXIS;
                n_b.neg[f][o] = (num < 0) ^ (d[j] < 0) ^ (d[a] < 0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
    end

    // stage C: products, then QW restoring divider stages
    logic [PW-1:0] c_prod [NFACE][2];
    logic [MW-1:0] r_rem  [QW+1][NFACE][2];
    logic [QW-1:0] r_lq   [QW+1][NFACE][2];
    t_cy           r_cy   [QW+1];
    logic          r_v    [QW+1];

    for (genvar f = 0; f < NFACE; f++) begin : g_prod
        for (genvar o = 0; o < 2; o++) begin : g_oth
            localparam int J = (f / 2 + 1 + o) % NAXIS;
            assign c_prod[f][o] = PW'(r_b.nmag[f]) * PW'(r_b.dmag[J]);
            always_ff @(posedge i_clk) begin
                r_rem[0][f][o] <= c_prod[f][o][PW-1:QW];
                r_lq[0][f][o]  <= c_prod[f][o][QW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cy[0] <= r_b;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cy[k] <= r_cy[k-1];
        end

        for (genvar f = 0; f < NFACE; f++) begin : g_f
            for (genvar o = 0; o < 2; o++) begin : g_o
                logic [MW:0]   t;
                logic [MW:0]   dv;
                logic          ge;
                logic [MW:0]   df;
                assign t  = {r_rem[k-1][f][o], r_lq[k-1][f][o][QW-1]};
                assign dv = {1'b0, r_cy[k-1].dmag[f/2]};
                assign ge = (t >= dv);
                assign df = t - dv;
                always_ff @(posedge i_clk) begin
                    r_rem[k][f][o] <= ge ? df[MW-1:0] : t[MW-1:0];
                    r_lq[k][f][o]  <= {r_lq[k-1][f][o][QW-2:0], ge};
                end
            end
        end
    end

    // stage E: hit points and box bounds per face
    t_cy        e_cy;
    t_hit       n_e_rec [NFACE];
    logic [NFACE-1:0] n_e_hit;
    t_hit       r_e_rec [NFACE];
    logic [NFACE-1:0] r_e_hit;
    logic       r_e_vld;

    assign e_cy = r_cy[QW];

    always_comb begin
        logic signed [NW-1:0] sj;
        logic signed [NW-1:0] cj;
        logic signed [NW-1:0] hj;
        logic signed [NW-1:0] qx;
        logic signed [NW-1:0] pe;
        logic                 inb;
        int a;
        int j;
        for (int f = 0; f < NFACE; f++) begin
            a = f / 2;
            inb = 1'b1;
            n_e_rec[f].face = 3'(f);
            n_e_rec[f].tn   = e_cy.nmag[f];
            n_e_rec[f].td   = e_cy.dmag[a];
            n_e_rec[f].p    = '0;
            n_e_rec[f].p[a] = e_cy.fp[f];
            for (int o = 0; o < 2; o++) begin
                j  = (a + 1 + o) % NAXIS;
                sj = NW'($signed(e_cy.s[j]));
                cj = NW'($signed(e_cy.c[j]));
                hj = $signed(NW'(e_cy.h[j]));
                qx = $signed({1'b0, r_lq[QW][f][o]});
                pe = e_cy.neg[f][o] ? sj - qx : sj + qx;
                if ((pe < cj - hj) || (pe > cj + hj)) begin
                    inb = 1'b0;
                end
                n_e_rec[f].p[j] = pe[W-1:0];
            end
            n_e_hit[f] = e_cy.ok[f] && inb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_rec <= n_e_rec;
        r_e_hit <= n_e_hit;
    end

    // stage F: keep the first two hits in face order
    t_hit       n_f_h0;
    t_hit       n_f_h1;
    logic [1:0] n_f_n;
    t_hit       r_f_h0;
    t_hit       r_f_h1;
    logic [1:0] r_f_n;
    logic       r_f_vld;

    always_comb begin
        n_f_h0 = '0;
        n_f_h1 = '0;
        n_f_n  = 2'd0;
        for (int f = 0; f < NFACE; f++) begin
            if (r_e_hit[f]) begin
                if (n_f_n == 2'd0) begin
                    n_f_h0 = r_e_rec[f];
                    n_f_n  = 2'd1;
                end else if (n_f_n == 2'd1) begin
                    n_f_h1 = r_e_rec[f];
                    n_f_n  = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_h0 <= n_f_h0;
        r_f_h1 <= n_f_h1;
        r_f_n  <= n_f_n;
    end

    // stage G: cross products for t ordering
    logic [PW-1:0] r_g_m0;
    logic [PW-1:0] r_g_m1;
    t_hit          r_g_h0;
    t_hit          r_g_h1;
    logic [1:0]    r_g_n;
    logic          r_g_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_m0 <= PW'(r_f_h0.tn) * PW'(r_f_h1.td);
        r_g_m1 <= PW'(r_f_h1.tn) * PW'(r_f_h0.td);
        r_g_h0 <= r_f_h0;
        r_g_h1 <= r_f_h1;
        r_g_n  <= r_f_n;
    end

    // stage H: order the pair, zero absent hits, output register
    logic swap;
    t_hit h_near;
    t_hit h_far;
    t_out n_out;
    t_out r_out;
    logic r_h_vld;

    assign swap   = (r_g_n == 2'd2) && (r_g_m0 > r_g_m1);
    assign h_near = swap ? r_g_h1 : r_g_h0;
    assign h_far  = swap ? r_g_h0 : r_g_h1;

    always_comb begin
        n_out = '0;
        n_out.hit_count = r_g_n;
        if (r_g_n != 2'd0) begin
            n_out.first_x    = h_near.p[0];
            n_out.first_y    = h_near.p[1];
            n_out.first_z    = h_near.p[2];
            n_out.first_face = h_near.face;
        end
        if (r_g_n == 2'd2) begin
            n_out.second_x    = h_far.p[0];
            n_out.second_y    = h_far.p[1];
            n_out.second_z    = h_far.p[2];
            n_out.second_face = h_far.face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_h_vld;
    assign o_result = r_out;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.hit_count != 2'd3))
        else $error("hit count out of range");

    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld |=> ##2 o_strobe)
        else $error("valid lost between select and output");

    a_no_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.hit_count != 2'd2)) |->
        ((o_result.second_face == 3'd0) && (o_result.second_x == '0)))
        else $error("absent second hit not zeroed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_vld && (r_g_n == 2'd2) && (r_g_m0 > r_g_m1)) |=>
        (o_result.first_face == $past(r_g_h1.face)))
        else $error("pair not swapped to put smaller t first");

endmodule
